>>> design/sector_cache_tag_controller_macros.svh
// Assertion macros shared by the sector cache tag controller.
`ifndef SECTOR_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SECTOR_CACHE_TAG_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define SCTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define SCTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sctc_pkg.sv
// Types and constants shared by the sector cache tag controller and its slot cells.
package sctc_pkg;

	localparam int CACHE_SLOTS = 8;
	localparam int IDX_W       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);
	localparam int TAG_W       = 32;
	localparam int SLOT_W      = 3;
	localparam int ACT_W       = 3;
	localparam int REQ_W       = 2;
	localparam int CFG_W       = 4;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_READY  = 3'd0,
		ACT_WBACK  = 3'd1,
		ACT_FILL   = 3'd2,
		ACT_BYPASS = 3'd3,
		ACT_DONE   = 3'd4
	} action_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_FLUSH = 2'd2,
		REQ_INVAL = 2'd3
	} req_t;

	// Broadcast to every cell: what the search looks for
	typedef struct packed {
		logic             flush;
		logic [TAG_W-1:0] sector;
		cnt_t             n;
		idx_t             vic_idx;
	} look_t;

	// Broadcast to every cell: state update for this cycle
	typedef struct packed {
		logic inval;
		logic wr;
		logic wr_dirty;
		logic set_dirty;
		logic clr_dirty;
		idx_t idx;
	} cmd_t;

	// Handed from cell to cell along the row
	typedef struct packed {
		logic             found;
		idx_t             idx;
		logic [TAG_W-1:0] tag;
		logic             vdirty;
		logic [TAG_W-1:0] vtag;
	} chain_t;

endpackage

>>> design/sector_cache_tag_controller.sv
// Tag controller of a fully associative write-back sector cache, round-robin replacement.
//
// Use: requests enter on in_valid/in_stall with req_type and sector; one word
// each. Results leave on out_valid/out_stall, one word per action, the final
// word of a request marked by last. cfg_we/cfg_wdata set slots_in_use; the user
// writes it only while the block is idle, which the block does not enforce;
// invalidate after changing it. A request is taken in the idle state and decided
// in the decide state, which loads the output register once it is free. Hit,
// bypass and invalidate give one word each; a clean miss fill and ready, a dirty
// miss writeback, fill and ready; a flush one writeback per dirty slot, then done.
// The sequencer emits one result word per cycle through a single output register
// while the receiver does not stall; the tag search runs through the row of slot
// cells in the decide state. One request is in work at a time; the next is taken
// while the last result word still waits in the output register.
// Reset: all slots invalid and clean, victim pointer at slot 0, slots_in_use
// at 8. A stalled receiver holds the output word and pauses the sequencer.
`include "sector_cache_tag_controller_macros.svh"

module sector_cache_tag_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sctc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sctc_pkg::REQ_W-1:0]   req_type,
	input  logic [sctc_pkg::TAG_W-1:0]   sector,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sctc_pkg::ACT_W-1:0]   action,
	output logic [sctc_pkg::SLOT_W-1:0]  slot,
	output logic [sctc_pkg::TAG_W-1:0]   disk_sector,
	output logic                         was_hit,
	output logic                         last
);
	import sctc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FILL,
		ST_READY,
		ST_FLUSH
	} state_t;

	state_t             state_q, state_d;
	req_t               req_q;
	logic [TAG_W-1:0]   sector_q;
	idx_t               victim_q, victim_d;
	idx_t               vp_q, vp_d;
	logic [CFG_W-1:0]   slots_q;

	logic               out_valid_q;
	action_t            action_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TAG_W-1:0]   disk_sector_q;
	logic               was_hit_q;
	logic               last_q;

	logic               out_free;
	logic               emit;
	action_t            e_action;
	logic [SLOT_W-1:0]  e_slot;
	logic [TAG_W-1:0]   e_sect;
	logic               e_hit;
	logic               e_last;

	cnt_t               n;
	idx_t               v;
	cnt_t               v_inc;
	idx_t               v_next;

	look_t              look;
	cmd_t               cmd;
	chain_t             chain [CACHE_SLOTS+1];
	chain_t             res;
	logic [CACHE_SLOTS-1:0] valid_vec;
	logic [CACHE_SLOTS-1:0] dirty_vec;

	// Row of slot cells
	assign chain[0] = '0;
	for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
		sctc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (idx_t'(g)),
			.look   (look),
			.cmd    (cmd),
			.cin    (chain[g]),
			.cout   (chain[g+1]),
			.valid  (valid_vec[g]),
			.dirty  (dirty_vec[g])
		);
	end
	assign res = chain[CACHE_SLOTS];

	// Effective slot count and round-robin victim
	always_comb begin
		if (int'(slots_q) > CACHE_SLOTS) begin
			n = cnt_t'(CACHE_SLOTS);
		end else begin
			n = cnt_t'(slots_q);
		end
		v      = (cnt_t'(vp_q) < n) ? vp_q : '0;
		v_inc  = cnt_t'(v) + cnt_t'(1);
		v_next = (v_inc >= n) ? '0 : idx_t'(v_inc);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign look.flush   = (state_q == ST_FLUSH);
	assign look.sector  = sector_q;
	assign look.n       = n;
	assign look.vic_idx = v;

	// Sequencer: next state, result word and slot updates
	always_comb begin
		state_d       = state_q;
		vp_d          = vp_q;
		victim_d      = victim_q;
		emit          = 1'b0;
		e_action      = ACT_DONE;
		e_slot        = '0;
		e_sect        = '0;
		e_hit         = 1'b0;
		e_last        = 1'b0;
		cmd.inval     = 1'b0;
		cmd.wr        = 1'b0;
		cmd.wr_dirty  = (req_q == REQ_WRITE);
		cmd.set_dirty = 1'b0;
		cmd.clr_dirty = 1'b0;
		cmd.idx       = victim_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					unique case (req_q) inside
						REQ_FLUSH: begin
							state_d = ST_FLUSH;
						end
						REQ_INVAL: begin
							cmd.inval = 1'b1;
							emit      = 1'b1;
							e_action  = ACT_DONE;
							e_last    = 1'b1;
							state_d   = ST_IDLE;
						end
						REQ_READ, REQ_WRITE: begin
							if (n == '0) begin
								emit     = 1'b1;
								e_action = ACT_BYPASS;
								e_sect   = sector_q;
								e_last   = 1'b1;
								state_d  = ST_IDLE;
							end else if (res.found) begin
								cmd.idx       = res.idx;
								cmd.set_dirty = (req_q == REQ_WRITE);
								emit          = 1'b1;
								e_action      = ACT_READY;
								e_slot        = SLOT_W'(res.idx);
								e_sect        = sector_q;
								e_hit         = 1'b1;
								e_last        = 1'b1;
								state_d       = ST_IDLE;
							end else begin
								vp_d     = v_next;
								victim_d = v;
								cmd.idx  = v;
								emit     = 1'b1;
								e_slot   = SLOT_W'(v);
								if (res.vdirty) begin
									e_action = ACT_WBACK;
									e_sect   = res.vtag;
									state_d  = ST_FILL;
								end else begin
									cmd.wr   = 1'b1;
									e_action = ACT_FILL;
									e_sect   = sector_q;
									state_d  = ST_READY;
								end
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_FILL: begin
				if (out_free) begin
					cmd.wr   = 1'b1;
					emit     = 1'b1;
					e_action = ACT_FILL;
					e_slot   = SLOT_W'(victim_q);
					e_sect   = sector_q;
					state_d  = ST_READY;
				end
			end
			ST_READY: begin
				if (out_free) begin
					emit     = 1'b1;
					e_action = ACT_READY;
					e_slot   = SLOT_W'(victim_q);
					e_sect   = sector_q;
					e_last   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					emit = 1'b1;
					if (res.found) begin
						cmd.idx       = res.idx;
						cmd.clr_dirty = 1'b1;
						e_action      = ACT_WBACK;
						e_slot        = SLOT_W'(res.idx);
						e_sect        = res.tag;
					end else begin
						e_action = ACT_DONE;
						e_last   = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, request hold and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			req_q         <= REQ_READ;
			sector_q      <= '0;
			victim_q      <= '0;
			vp_q          <= '0;
			out_valid_q   <= 1'b0;
			action_q      <= ACT_DONE;
			slot_q        <= '0;
			disk_sector_q <= '0;
			was_hit_q     <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			state_q  <= state_d;
			vp_q     <= vp_d;
			victim_q <= victim_d;
			if (state_q == ST_IDLE && in_valid) begin
				req_q    <= req_t'(req_type);
				sector_q <= sector;
			end
			if (emit) begin
				out_valid_q   <= 1'b1;
				action_q      <= e_action;
				slot_q        <= e_slot;
				disk_sector_q <= e_sect;
				was_hit_q     <= e_hit;
				last_q        <= e_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 4'd8;
		end else if (cfg_we) begin
			slots_q <= cfg_wdata;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign slot        = slot_q;
	assign disk_sector = disk_sector_q;
	assign was_hit     = was_hit_q;
	assign last        = last_q;

	// Checks
	`SCTC_ASSERT_NXT(a_accept_decide, in_valid && !in_stall, state_q == ST_DECIDE, "request not decided after accept")
	`SCTC_ASSERT_IMP(a_hit_ready, out_valid && was_hit, action == ACT_READY && last, "hit flag on a non-final word")
	`SCTC_ASSERT_IMP(a_dirty_valid, 1'b1, (dirty_vec & ~valid_vec) == '0, "dirty mark on an invalid slot")

endmodule

>>> design/sctc_cell.sv
// One cache slot: tag, valid and dirty marks, and its link in the search chain.
module sctc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sctc_pkg::idx_t  my_idx,
	input  sctc_pkg::look_t look,
	input  sctc_pkg::cmd_t  cmd,
	input  sctc_pkg::chain_t cin,
	output sctc_pkg::chain_t cout,
	output logic            valid,
	output logic            dirty
);
	import sctc_pkg::*;

	logic             valid_q;
	logic             dirty_q;
	logic [TAG_W-1:0] tag_q;
	logic             sel;
	logic             in_use;
	logic             match;
	logic             take;
	logic             is_vic;

	assign sel    = (cmd.idx == my_idx);
	assign in_use = (cnt_t'(my_idx) < look.n);
	assign is_vic = (look.vic_idx == my_idx);

	// Candidate: dirty slot for flush, tag match for lookup
	assign match = valid_q && in_use && (look.flush ? dirty_q : (tag_q == look.sector));
	assign take  = match && !cin.found;

	// Pass the lowest candidate and the victim's state along the row
	always_comb begin
		cout.found  = cin.found || match;
		cout.idx    = take ? my_idx : cin.idx;
		cout.tag    = take ? tag_q : cin.tag;
		cout.vdirty = cin.vdirty || (is_vic && valid_q && dirty_q);
		cout.vtag   = is_vic ? tag_q : cin.vtag;
	end

	// Valid and dirty marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (cmd.inval) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (cmd.wr && sel) begin
			valid_q <= 1'b1;
			dirty_q <= cmd.wr_dirty;
		end else if (cmd.set_dirty && sel) begin
			dirty_q <= 1'b1;
		end else if (cmd.clr_dirty && sel) begin
			dirty_q <= 1'b0;
		end
	end

	// Tag, written on fill
	always_ff @(posedge clk) begin
		if (cmd.wr && sel) begin
			tag_q <= look.sector;
		end
	end

	assign valid = valid_q;
	assign dirty = dirty_q;

endmodule
